FILE: design/grc_pkg.sv
// Shared types, constants and the sine table for the grid ray caster.
`default_nettype none
package grc_pkg;

  localparam int POS_W      = 15;
  localparam int ANG_W      = 12;
  localparam int DIST_W     = 16;
  localparam int MAP_W      = 64;
  localparam int DIR_W      = 15;
  localparam int FRAC_BITS  = 6;
  localparam int SINE_N     = (1 << (ANG_W - 2)) + 1;
  localparam int SINE_AW    = $clog2(SINE_N);

  localparam int GRID_SIZE_DEF  = 8;
  localparam int MAX_STEPS_DEF  = 8;
  localparam int CELL_SHIFT_DEF = 6;

  typedef struct packed {
    logic [POS_W-1:0] player_x;
    logic [POS_W-1:0] player_y;
    logic [ANG_W-1:0] ray_angle;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  hit_x;
    logic [POS_W-1:0]  hit_y;
    logic [DIST_W-1:0] hit_distance;
    logic              hit_side;
    logic              found;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic             dx_neg;
    logic [DIR_W-1:0] dx_mag;
    logic             dy_neg;
    logic [DIR_W-1:0] dy_mag;
  } ray_t;

  typedef logic [DIR_W-1:0] sine_rom_t [SINE_N];

  // quarter-wave sine in Q14, odd Taylor series to x^7 evaluated in Q30
  function automatic sine_rom_t sine_table();
    sine_rom_t  tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] one;
    one = 64'd1 << 30;
    for (int r = 0; r < SINE_N; r++) begin
      x  = 64'(r) * 64'd1647099;
      x2 = (x * x) >> 30;
      t  = one - x2 / 64'd42;
      t  = one - ((x2 * t) >> 30) / 64'd20;
      t  = one - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      tab[r] = DIR_W'((s + (64'd1 << 15)) >> 16);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

FILE: design/grid_ray_caster.sv
// Top level of the grid ray caster.
//
// in_*  : one ray per beat (player_x, player_y 9.6 unsigned, ray_angle 12-bit turn).
// out_* : one result per ray (hit point, 10.6 distance, line kind, found).
// cfg_* : writes the 64-bit wall bitmap; always ready, write only while idle.
// The front end looks the direction up in a sine ROM and queues the ray in
// a two-entry queue. The back end walks horizontal then vertical grid lines;
// each crossing costs a multiply, a serial restoring divide and a cell test.
// A ray that hits early or skips a pass finishes sooner. The distance is then
// taken with a serial square root. Throughput is one ray per back end walk.
// The result sits in an output register; while the receiver stalls the back
// end holds the next finished ray and the front end keeps filling the queue.
// Reset clears the wall map to zero and empties all stages.
`default_nettype none
module grid_ray_caster import grc_pkg::*; #(
  parameter int GRID_SIZE  = GRID_SIZE_DEF,
  parameter int MAX_STEPS  = MAX_STEPS_DEF,
  parameter int CELL_SHIFT = CELL_SHIFT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MAP_W-1:0] cfg_data
);

  logic [MAP_W-1:0] wall_map_r;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  ray_t             push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_map_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      wall_map_r <= cfg_data;
    end
  end

  grc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  grc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  grc_back #(
    .GRID_SIZE  (GRID_SIZE),
    .MAX_STEPS  (MAX_STEPS),
    .CELL_SHIFT (CELL_SHIFT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .wall_map  (wall_map_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: design/grc_front.sv
// Front end: takes rays, looks up the direction vector and classifies its signs.
`default_nettype none
module grc_front import grc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push_valid,
  input  logic     push_ready,
  output ray_t     push_data
);

  localparam sine_rom_t SINE_ROM = sine_table();
  localparam logic [SINE_AW-1:0] QTR = SINE_AW'(SINE_N - 1);

  logic                s1_valid_r, s1_valid_nxt;
  logic [DIR_W-1:0]    sx_r, sy_r;
  logic                negx_r, negy_r;
  logic [POS_W-1:0]    px_r, py_r;
  logic [ANG_W-1:0]    ang_x;
  logic [SINE_AW-1:0]  idx_x, idx_y;
  logic                in_fire;

  assign in_ready = !s1_valid_r && push_ready;
  assign in_fire  = in_valid && in_ready;
  assign ang_x    = in_data.ray_angle + ANG_W'(SINE_N - 1);

  always_comb begin
    idx_x = {1'b0, ang_x[ANG_W-3:0]};
    idx_y = {1'b0, in_data.ray_angle[ANG_W-3:0]};
    if (ang_x[ANG_W-2]) idx_x = QTR - idx_x;
    if (in_data.ray_angle[ANG_W-2]) idx_y = QTR - idx_y;
  end

  assign s1_valid_nxt = in_fire || (s1_valid_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sx_r   <= SINE_ROM[idx_x];
      sy_r   <= SINE_ROM[idx_y];
      negx_r <= ang_x[ANG_W-1];
      negy_r <= !in_data.ray_angle[ANG_W-1];
      px_r   <= in_data.player_x;
      py_r   <= in_data.player_y;
    end
  end

  assign push_valid       = s1_valid_r;
  assign push_data.px     = px_r;
  assign push_data.py     = py_r;
  assign push_data.dx_mag = sx_r;
  assign push_data.dy_mag = sy_r;
  assign push_data.dx_neg = negx_r && (sx_r != '0);
  assign push_data.dy_neg = negy_r && (sy_r != '0);

endmodule
`default_nettype wire

FILE: design/grc_fifo.sv
// Two-entry queue between the front end and the walker.
`default_nettype none
module grc_fifo import grc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  ray_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output ray_t pop_data
);

  ray_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

FILE: design/grc_back.sv
// Back end: walks grid-line crossings with a serial divider, picks the hit, takes the root.
`default_nettype none
module grc_back import grc_pkg::*; #(
  parameter int GRID_SIZE  = GRID_SIZE_DEF,
  parameter int MAX_STEPS  = MAX_STEPS_DEF,
  parameter int CELL_SHIFT = CELL_SHIFT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  ray_t             pop_data,
  input  logic [MAP_W-1:0] wall_map,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int RAW     = CELL_SHIFT + FRAC_BITS;
  localparam int CELL    = 1 << RAW;
  localparam int SPAN    = GRID_SIZE * CELL;
  localparam int POS_LIM = (1 << POS_W) - 1;
  localparam int D_W     = $clog2(((SPAN > POS_LIM) ? SPAN : POS_LIM) + 1);
  localparam int OFF_W   = $clog2(MAX_STEPS * CELL + 1);
  localparam int P_W     = OFF_W + DIR_W;
  localparam int B_W     = P_W + 2;
  localparam int LN_W    = $clog2(POS_LIM + 1 + (MAX_STEPS + GRID_SIZE + 1) * CELL) + 1;
  localparam int SQ_W    = 2 * D_W + 1;
  localparam int RT_N    = D_W + 1;
  localparam int K_W     = $clog2(MAX_STEPS + 1);
  localparam int DC_W    = $clog2(P_W + 1);
  localparam int RC_W    = $clog2(RT_N + 1);
  localparam int G_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int NCELL   = GRID_SIZE * GRID_SIZE;
  localparam int CI_W    = $clog2(NCELL);

  localparam logic signed [LN_W-1:0] CELL_LN = LN_W'(CELL);
  localparam logic signed [LN_W-1:0] SPAN_LN = LN_W'(SPAN);
  localparam logic signed [LN_W-1:0] PLIM_LN = LN_W'(POS_LIM);
  localparam logic signed [B_W-1:0]  SPAN_B  = B_W'(SPAN);
  localparam logic signed [B_W-1:0]  PLIM_B  = B_W'(POS_LIM);
  localparam logic [LN_W-1:0]        LOW_MASK = LN_W'(CELL - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_TEST = 4'd4;
  localparam logic [3:0] ST_SQ   = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_NEXT = 4'd7;
  localparam logic [3:0] ST_SEL  = 4'd8;
  localparam logic [3:0] ST_ROOT = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic                    pass_r;
  ray_t                    item_r;
  logic signed [LN_W-1:0]  line_r;
  logic [OFF_W-1:0]        off_r;
  logic [K_W-1:0]          k_r;
  logic [P_W-1:0]          prod_r, quo_r;
  logic [DIR_W:0]          rem_r;
  logic [DC_W-1:0]         dcnt_r;
  logic [RC_W-1:0]         rcnt_r;
  logic [D_W-1:0]          hitoff_r, hitq_r;
  logic [2*D_W-1:0]        sqa_r, sqb_r;
  logic                    found_h_r, found_v_r;
  logic [POS_W-1:0]        hx_h_r, hy_h_r, hx_v_r, hy_v_r;
  logic [SQ_W-1:0]         dh_r, dv_r;
  logic [SQ_W:0]           v_r, res_r, bit_r;
  logic [POS_W-1:0]        sel_x_r, sel_y_r;
  logic                    sel_side_r, sel_found_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic                    da_neg, db_neg;
  logic [DIR_W-1:0]        da_mag, db_mag;
  logic [POS_W-1:0]        a0, b0;
  logic signed [LN_W-1:0]  a0_ln, line_base, line0, line_adj;
  logic [OFF_W-1:0]        off0;
  logic [DIR_W:0]          rem_sh;
  logic                    div_ge;
  logic signed [B_W-1:0]   b_s, q_s;
  logic                    ca_ok, cb_ok, hit;
  logic [G_W-1:0]          ca, cb, col, row;
  logic [CI_W-1:0]         cidx;
  logic [NCELL-1:0]        map_used;
  logic [POS_W-1:0]        line_cl, b_cl;
  logic                    last_step, take_v, out_load;
  logic [SQ_W:0]           rt_try;

  assign da_neg = pass_r ? item_r.dx_neg : item_r.dy_neg;
  assign da_mag = pass_r ? item_r.dx_mag : item_r.dy_mag;
  assign db_neg = pass_r ? item_r.dy_neg : item_r.dx_neg;
  assign db_mag = pass_r ? item_r.dy_mag : item_r.dx_mag;
  assign a0     = pass_r ? item_r.px : item_r.py;
  assign b0     = pass_r ? item_r.py : item_r.px;

  always_comb begin
    a0_ln     = signed'({{(LN_W-POS_W){1'b0}}, a0});
    line_base = a0_ln & signed'(~LOW_MASK);
    line0     = da_neg ? line_base : line_base + CELL_LN;
    off0      = da_neg ? OFF_W'(a0_ln - line_base) : OFF_W'(line0 - a0_ln);
  end

  assign rem_sh = {rem_r[DIR_W-1:0], prod_r[P_W-1]};
  assign div_ge = (rem_sh >= {1'b0, da_mag});

  // crossing test on the current line
  always_comb begin
    q_s      = signed'({2'b00, quo_r});
    b_s      = signed'({{(B_W-POS_W){1'b0}}, b0}) + (db_neg ? -q_s : q_s);
    cb_ok    = (b_s >= 0) && (b_s < SPAN_B);
    cb       = b_s[RAW +: G_W];
    line_adj = da_neg ? line_r - CELL_LN : line_r;
    ca_ok    = (line_adj >= 0) && (line_adj < SPAN_LN);
    ca       = line_adj[RAW +: G_W];
    col      = pass_r ? ca : cb;
    row      = pass_r ? cb : ca;
    cidx     = CI_W'(row) * CI_W'(GRID_SIZE) + CI_W'(col);
    map_used = wall_map[NCELL-1:0];
    hit      = ca_ok && cb_ok && map_used[cidx];
    line_cl  = (line_r > PLIM_LN) ? POS_W'(POS_LIM) : line_r[POS_W-1:0];
    b_cl     = (b_s > PLIM_B) ? POS_W'(POS_LIM) : b_s[POS_W-1:0];
  end

  assign last_step = (k_r == K_W'(MAX_STEPS - 1));
  assign take_v    = found_v_r && (!found_h_r || (dv_r < dh_r));
  assign rt_try    = res_r + bit_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign pop_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pop_valid) state_nxt = ST_INIT;
      ST_INIT: state_nxt = (da_mag == '0) ? ST_NEXT : ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (dcnt_r == DC_W'(P_W - 1)) state_nxt = ST_TEST;
      ST_TEST: begin
        if (hit) state_nxt = ST_SQ;
        else if (last_step) state_nxt = ST_NEXT;
        else state_nxt = ST_MUL;
      end
      ST_SQ:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = pass_r ? ST_SEL : ST_INIT;
      ST_SEL:  state_nxt = ST_ROOT;
      ST_ROOT: if (rcnt_r == RC_W'(RT_N - 1)) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) pass_r <= 1'b0;
      else if (state_r == ST_NEXT) pass_r <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        item_r    <= pop_data;
        found_h_r <= 1'b0;
        found_v_r <= 1'b0;
      end
      ST_INIT: begin
        line_r <= line0;
        off_r  <= off0;
        k_r    <= '0;
      end
      ST_MUL: begin
        prod_r <= P_W'(off_r) * P_W'(db_mag);
        rem_r  <= '0;
        quo_r  <= '0;
        dcnt_r <= '0;
      end
      ST_DIV: begin
        rem_r  <= div_ge ? rem_sh - {1'b0, da_mag} : rem_sh;
        quo_r  <= {quo_r[P_W-2:0], div_ge};
        prod_r <= prod_r << 1;
        dcnt_r <= dcnt_r + DC_W'(1);
      end
      ST_TEST: begin
        hitoff_r <= D_W'(off_r);
        hitq_r   <= D_W'(quo_r);
        if (hit) begin
          if (pass_r) begin
            found_v_r <= 1'b1;
            hx_v_r    <= line_cl;
            hy_v_r    <= b_cl;
          end else begin
            found_h_r <= 1'b1;
            hx_h_r    <= b_cl;
            hy_h_r    <= line_cl;
          end
        end else begin
          line_r <= da_neg ? line_r - CELL_LN : line_r + CELL_LN;
          off_r  <= off_r + OFF_W'(CELL);
          k_r    <= k_r + K_W'(1);
        end
      end
      ST_SQ: begin
        sqa_r <= (2*D_W)'(hitoff_r) * (2*D_W)'(hitoff_r);
        sqb_r <= (2*D_W)'(hitq_r) * (2*D_W)'(hitq_r);
      end
      ST_SUM: begin
        if (pass_r) dv_r <= {1'b0, sqa_r} + {1'b0, sqb_r};
        else dh_r <= {1'b0, sqa_r} + {1'b0, sqb_r};
      end
      ST_NEXT: begin
      end
      ST_SEL: begin
        res_r  <= '0;
        bit_r  <= (SQ_W+1)'(1) << (2 * D_W);
        rcnt_r <= '0;
        if (take_v) begin
          v_r         <= {1'b0, dv_r};
          sel_x_r     <= hx_v_r;
          sel_y_r     <= hy_v_r;
          sel_side_r  <= 1'b1;
          sel_found_r <= 1'b1;
        end else if (found_h_r) begin
          v_r         <= {1'b0, dh_r};
          sel_x_r     <= hx_h_r;
          sel_y_r     <= hy_h_r;
          sel_side_r  <= 1'b0;
          sel_found_r <= 1'b1;
        end else begin
          v_r         <= '0;
          sel_x_r     <= item_r.px;
          sel_y_r     <= item_r.py;
          sel_side_r  <= 1'b0;
          sel_found_r <= 1'b0;
        end
      end
      ST_ROOT: begin
        if (v_r >= rt_try) begin
          v_r   <= v_r - rt_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        rcnt_r <= rcnt_r + RC_W'(1);
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_r.hit_x        <= sel_x_r;
          out_data_r.hit_y        <= sel_y_r;
          out_data_r.hit_side     <= sel_side_r;
          out_data_r.found        <= sel_found_r;
          out_data_r.hit_distance <= (res_r > (SQ_W+1)'((1 << DIST_W) - 1)) ?
                                     {DIST_W{1'b1}} : res_r[DIST_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dcnt_r < DC_W'(P_W)))
    else $error("divider ran past its last bit");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST) |-> (k_r < K_W'(MAX_STEPS)))
    else $error("line walk exceeded step limit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      (out_data_r.hit_distance == '0 && !out_data_r.hit_side))
    else $error("miss beat carries distance or side");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside done state");

endmodule
`default_nettype wire
